>>> design/sc_pkg.sv
// Shared types, fixed-point constants and the arctangent table for the
// spherical/cartesian converter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sc_pkg;

    localparam int CORDIC_STAGES_DEF = 20;

    localparam int XY_W   = 60;
    localparam int ANG_W  = 35;
    localparam int RAD_W  = 64;
    localparam int REM_W  = 34;
    localparam int ROOT_W = 32;
    localparam int TRIG_W = 33;

    localparam logic signed [ANG_W-1:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 35'sd6746518852;
    localparam logic signed [XY_W-1:0]  GAIN_Q30    = 60'sh26DD3B6A;

    localparam logic [17:0] POLAR_MAX   = 18'd205887;
    localparam logic [18:0] AZIMUTH_MAX = 19'd411774;

    localparam logic [31:0] ATAN_TAB [32] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
        32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
        32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
        32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
        32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic signed [XY_W-1:0]  x;
        logic signed [XY_W-1:0]  y;
        logic signed [ANG_W-1:0] a;
    } t_rot;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_root;

    typedef struct packed {
        logic               func;
        logic               err;
        logic [31:0]        r;
        logic [17:0]        pol;
        logic [18:0]        az;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_sq_side;

    typedef struct packed {
        logic        func;
        logic        err;
        logic        neg_a;
        logic        neg_b;
        logic        zero_a;
        logic        zero_b;
        logic        pi_a;
        logic        pi_b;
        logic [31:0] r;
        logic [31:0] rad;
    } t_cr_side;

endpackage

`default_nettype wire

>>> design/sc_sqrt_cell.sv
// One digit of the restoring square root, two lanes side by side.
// Depends on sc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sc_sqrt_cell (
    input  logic             i_clk,
    input  logic             i_en,
    input  sc_pkg::t_root    i_a,
    input  sc_pkg::t_root    i_b,
    input  sc_pkg::t_sq_side i_side,
    output sc_pkg::t_root    o_a,
    output sc_pkg::t_root    o_b,
    output sc_pkg::t_sq_side o_side
);

    function automatic sc_pkg::t_root step(input sc_pkg::t_root s);
        logic [sc_pkg::REM_W+1:0] rs;
        logic [sc_pkg::REM_W+1:0] trial;
        sc_pkg::t_root            o;
        rs    = {s.rem, s.rad[sc_pkg::RAD_W-1 -: 2]};
        trial = {2'b00, s.root, 2'b01};
        o.rad = {s.rad[sc_pkg::RAD_W-3:0], 2'b00};
        if (rs >= trial) begin
            o.rem  = sc_pkg::REM_W'(rs - trial);
            o.root = {s.root[sc_pkg::ROOT_W-2:0], 1'b1};
        end else begin
            o.rem  = rs[sc_pkg::REM_W-1:0];
            o.root = {s.root[sc_pkg::ROOT_W-2:0], 1'b0};
        end
        return o;
    endfunction

    sc_pkg::t_root    r_a, r_b, n_a, n_b;
    sc_pkg::t_sq_side r_side;

    always_comb begin
        n_a = step(i_a);
        n_b = step(i_b);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a    <= n_a;
            r_b    <= n_b;
            r_side <= i_side;
        end
    end

    assign o_a    = r_a;
    assign o_b    = r_b;
    assign o_side = r_side;

endmodule

`default_nettype wire

>>> design/sc_cordic_cell.sv
// One CORDIC micro-rotation for two lanes; rotation or vectoring per beat.
// Depends on sc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sc_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  sc_pkg::t_rot     i_a,
    input  sc_pkg::t_rot     i_b,
    input  sc_pkg::t_cr_side i_side,
    output sc_pkg::t_rot     o_a,
    output sc_pkg::t_rot     o_b,
    output sc_pkg::t_cr_side o_side
);

    function automatic sc_pkg::t_rot step(input sc_pkg::t_rot s, input logic vec);
        logic signed [sc_pkg::XY_W-1:0]  xs;
        logic signed [sc_pkg::XY_W-1:0]  ys;
        logic signed [sc_pkg::ANG_W-1:0] atn;
        logic                            sub;
        sc_pkg::t_rot                    o;
        xs  = s.x >>> IDX;
        ys  = s.y >>> IDX;
        atn = sc_pkg::ANG_W'(sc_pkg::ATAN_TAB[IDX]);
        sub = vec ? s.y[sc_pkg::XY_W-1] : ~s.a[sc_pkg::ANG_W-1];
        if (sub) begin
            o.x = s.x - ys;
            o.y = s.y + xs;
            o.a = s.a - atn;
        end else begin
            o.x = s.x + ys;
            o.y = s.y - xs;
            o.a = s.a + atn;
        end
        return o;
    endfunction

    sc_pkg::t_rot     r_a, r_b, n_a, n_b;
    sc_pkg::t_cr_side r_side;

    always_comb begin
        n_a = step(i_a, i_side.func);
        n_b = step(i_b, i_side.func);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a    <= n_a;
            r_b    <= n_b;
            r_side <= i_side;
        end
    end

    assign o_a    = r_a;
    assign o_b    = r_b;
    assign o_side = r_side;

endmodule

`default_nettype wire

>>> design/spherical_cartesian_converter.sv
// Spherical/cartesian converter top level: input capture, squares, square-root
// cells, CORDIC cells and the multiply/round stages. Depends on sc_pkg,
// sc_sqrt_cell and sc_cordic_cell.
//
// Input channel i_valid/o_ready carries one point per beat with i_func
// selecting spherical to cartesian (0) or cartesian to spherical (1).
// Output channel o_valid/i_ready carries one result per beat.
// The pipeline holds, in order, the capture, squares and sums stages, 32
// square-root cells, one set-up stage, one CORDIC cell per stage and four
// multiply/round/output stages. A new point can be taken every cycle while
// o_ready is high; throughput is one point per cycle without output stalls.
// Every stage has its own valid bit and advances when it is empty or the
// stage after it advances, so while the receiver stalls the pipeline keeps
// taking points until every stage is full; only then does o_ready drop.
// Reset clears all valid bits; the pipeline is empty after reset and no
// clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module spherical_cartesian_converter #(
    parameter int CORDIC_STAGES = sc_pkg::CORDIC_STAGES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_func,
    input  logic [31:0]        i_radius_in,
    input  logic [17:0]        i_polar_in,
    input  logic [18:0]        i_azimuth_in,
    input  logic signed [31:0] i_x_in,
    input  logic signed [31:0] i_y_in,
    input  logic signed [31:0] i_z_in,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_x_out,
    output logic signed [31:0] o_y_out,
    output logic signed [31:0] o_z_out,
    output logic [31:0]        o_radius_out,
    output logic [17:0]        o_polar_out,
    output logic [18:0]        o_azimuth_out,
    output logic               o_range_error
);

    localparam int ANG_W  = sc_pkg::ANG_W;
    localparam int XY_W   = sc_pkg::XY_W;
    localparam int TRIG_W = sc_pkg::TRIG_W;
    localparam int RT_N   = sc_pkg::ROOT_W;
    localparam int ST_IN  = 0;
    localparam int ST_SQ  = 1;
    localparam int ST_SUM = 2;
    localparam int ST_RT0 = 3;
    localparam int ST_PRE = ST_RT0 + RT_N;
    localparam int ST_CR0 = ST_PRE + 1;
    localparam int ST_M1  = ST_CR0 + CORDIC_STAGES;
    localparam int ST_M2  = ST_M1 + 1;
    localparam int ST_M3  = ST_M2 + 1;
    localparam int ST_OUT = ST_M3 + 1;
    localparam int NSTG   = ST_OUT + 1;

    localparam logic signed [67:0]    RND30  = 68'sd536870912;
    localparam logic signed [65:0]    RND30P = 66'sd536870912;
    localparam logic signed [67:0]    SAT_HI = 68'sd2147483647;
    localparam logic signed [67:0]    SAT_LO = -68'sd2147483648;
    localparam logic signed [ANG_W:0] RND14  = 36'sd8192;

    function automatic logic signed [31:0] rnd_sat(input logic signed [67:0] v);
        logic signed [67:0] t;
        t = (v + RND30) >>> 30;
        if (t > SAT_HI) begin
            return 32'sh7FFFFFFF;
        end else if (t < SAT_LO) begin
            return 32'sh80000000;
        end
        return t[31:0];
    endfunction

    function automatic logic [18:0] to_q316(input logic signed [ANG_W:0] a,
                                            input logic [18:0] hi);
        logic signed [ANG_W:0] v;
        v = (a + RND14) >>> 14;
        if (v < 0) begin
            return 19'd0;
        end else if (v > $signed({{(ANG_W-18){1'b0}}, hi})) begin
            return hi;
        end
        return v[18:0];
    endfunction

    function automatic logic [ANG_W:0] rot_reduce(input logic signed [ANG_W-1:0] a0);
        logic signed [ANG_W-1:0] a;
        logic                    neg;
        a   = a0;
        neg = 1'b0;
        if (a > sc_pkg::HALF_PI_Q30) begin
            a   = a - sc_pkg::PI_Q30;
            neg = 1'b1;
            if (a > sc_pkg::HALF_PI_Q30) begin
                a   = a - sc_pkg::PI_Q30;
                neg = 1'b0;
            end
        end
        return {neg, a};
    endfunction

    function automatic sc_pkg::t_rot vec_init(input logic signed [32:0] yv,
                                              input logic signed [32:0] xv);
        logic signed [XY_W-1:0] xs;
        logic signed [XY_W-1:0] ys;
        sc_pkg::t_rot           o;
        xs = {{(XY_W-57){xv[32]}}, xv, 24'd0};
        ys = {{(XY_W-57){yv[32]}}, yv, 24'd0};
        if (xv[32]) begin
            o.x = -xs;
            o.y = -ys;
            o.a = sc_pkg::PI_Q30;
        end else begin
            o.x = xs;
            o.y = ys;
            o.a = '0;
        end
        return o;
    endfunction

    // stage handshake
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] en;

    assign en[NSTG-1] = ~r_vld[NSTG-1] | i_ready;
    for (genvar k = 0; k < NSTG - 1; k++) begin : g_en
        assign en[k] = ~r_vld[k] | en[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= (en & {r_vld[NSTG-2:0], i_valid}) | (~en & r_vld);
        end
    end

    assign o_ready = en[ST_IN];
    assign o_valid = r_vld[ST_OUT];

    // capture
    sc_pkg::t_sq_side r_in, n_in;

    always_comb begin
        n_in.func = i_func;
        n_in.err  = ~i_func & ((i_polar_in > sc_pkg::POLAR_MAX) |
                               (i_azimuth_in > sc_pkg::AZIMUTH_MAX));
        n_in.r    = i_radius_in;
        n_in.pol  = i_polar_in;
        n_in.az   = i_azimuth_in;
        n_in.x    = i_x_in;
        n_in.y    = i_y_in;
        n_in.z    = i_z_in;
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_IN]) begin
            r_in <= n_in;
        end
    end

    // squares
    sc_pkg::t_sq_side   r_sq_side;
    logic signed [63:0] n_xx, n_yy, n_zz;
    logic [63:0]        r_xx, r_yy, r_zz;

    always_comb begin
        n_xx = r_in.x * r_in.x;
        n_yy = r_in.y * r_in.y;
        n_zz = r_in.z * r_in.z;
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_SQ]) begin
            r_sq_side <= r_in;
            r_xx      <= n_xx;
            r_yy      <= n_yy;
            r_zz      <= n_zz;
        end
    end

    // sums, held in 64 bits without overflow
    sc_pkg::t_sq_side r_sum_side;
    logic [63:0]      r_sall, r_sxy, n_sxy;

    assign n_sxy = r_xx + r_yy;

    always_ff @(posedge i_clk) begin
        if (en[ST_SUM]) begin
            r_sum_side <= r_sq_side;
            r_sxy      <= n_sxy;
            r_sall     <= n_sxy + r_zz;
        end
    end

    // square-root cells
    sc_pkg::t_root    rt_a    [RT_N+1];
    sc_pkg::t_root    rt_b    [RT_N+1];
    sc_pkg::t_sq_side rt_side [RT_N+1];

    assign rt_a[0]    = '{rad: r_sall, rem: '0, root: '0};
    assign rt_b[0]    = '{rad: r_sxy, rem: '0, root: '0};
    assign rt_side[0] = r_sum_side;

    for (genvar k = 0; k < RT_N; k++) begin : g_rt
        sc_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (en[ST_RT0+k]),
            .i_a    (rt_a[k]),
            .i_b    (rt_b[k]),
            .i_side (rt_side[k]),
            .o_a    (rt_a[k+1]),
            .o_b    (rt_b[k+1]),
            .o_side (rt_side[k+1])
        );
    end

    // CORDIC set-up
    sc_pkg::t_rot     r_pre_a, r_pre_b, n_pre_a, n_pre_b;
    sc_pkg::t_cr_side r_pre_side, n_pre_side;
    sc_pkg::t_sq_side sq;
    logic [ANG_W:0]   red_a, red_b;

    always_comb begin
        sq    = rt_side[RT_N];
        red_a = rot_reduce(ANG_W'({sq.pol, 14'd0}));
        red_b = rot_reduce(ANG_W'({sq.az, 14'd0}));
        n_pre_side.func   = sq.func;
        n_pre_side.err    = sq.err;
        n_pre_side.r      = sq.r;
        n_pre_side.rad    = rt_a[RT_N].root;
        n_pre_side.neg_a  = 1'b0;
        n_pre_side.neg_b  = 1'b0;
        n_pre_side.zero_a = 1'b0;
        n_pre_side.zero_b = 1'b0;
        n_pre_side.pi_a   = 1'b0;
        n_pre_side.pi_b   = 1'b0;
        if (sq.func) begin
            n_pre_a = vec_init({1'b0, rt_b[RT_N].root}, {sq.z[31], sq.z});
            n_pre_b = vec_init({sq.y[31], sq.y}, {sq.x[31], sq.x});
            n_pre_side.zero_a = (rt_b[RT_N].root == '0);
            n_pre_side.pi_a   = sq.z[31];
            n_pre_side.zero_b = (sq.y == '0);
            n_pre_side.pi_b   = sq.x[31];
        end else begin
            n_pre_a.x = sc_pkg::GAIN_Q30;
            n_pre_a.y = '0;
            n_pre_a.a = red_a[ANG_W-1:0];
            n_pre_b.x = sc_pkg::GAIN_Q30;
            n_pre_b.y = '0;
            n_pre_b.a = red_b[ANG_W-1:0];
            n_pre_side.neg_a = red_a[ANG_W];
            n_pre_side.neg_b = red_b[ANG_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_PRE]) begin
            r_pre_a    <= n_pre_a;
            r_pre_b    <= n_pre_b;
            r_pre_side <= n_pre_side;
        end
    end

    // CORDIC cells
    sc_pkg::t_rot     cr_a    [CORDIC_STAGES+1];
    sc_pkg::t_rot     cr_b    [CORDIC_STAGES+1];
    sc_pkg::t_cr_side cr_side [CORDIC_STAGES+1];

    assign cr_a[0]    = r_pre_a;
    assign cr_b[0]    = r_pre_b;
    assign cr_side[0] = r_pre_side;

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cr
        sc_cordic_cell #(
            .IDX (k)
        ) u_cell (
            .i_clk  (i_clk),
            .i_en   (en[ST_CR0+k]),
            .i_a    (cr_a[k]),
            .i_b    (cr_b[k]),
            .i_side (cr_side[k]),
            .o_a    (cr_a[k+1]),
            .o_b    (cr_b[k+1]),
            .o_side (cr_side[k+1])
        );
    end

    // first products and raw angles
    sc_pkg::t_rot             ca, cb;
    sc_pkg::t_cr_side         r_m1_side, cs;
    logic signed [XY_W-1:0]   st_w, ct_w, sp_w, cp_w;
    logic signed [TRIG_W-1:0] st, ct;
    logic signed [TRIG_W-1:0] r_m1_sp, r_m1_cp, n_m1_sp, n_m1_cp;
    logic signed [65:0]       r_m1_p, r_m1_z, n_m1_p, n_m1_z;
    logic signed [ANG_W-1:0]  r_m1_pol, r_m1_az, n_m1_pol, n_m1_az;

    always_comb begin
        ca   = cr_a[CORDIC_STAGES];
        cb   = cr_b[CORDIC_STAGES];
        cs   = cr_side[CORDIC_STAGES];
        st_w = cs.neg_a ? -ca.y : ca.y;
        ct_w = cs.neg_a ? -ca.x : ca.x;
        sp_w = cs.neg_b ? -cb.y : cb.y;
        cp_w = cs.neg_b ? -cb.x : cb.x;
        st      = st_w[TRIG_W-1:0];
        ct      = ct_w[TRIG_W-1:0];
        n_m1_sp = sp_w[TRIG_W-1:0];
        n_m1_cp = cp_w[TRIG_W-1:0];
        n_m1_p  = $signed({1'b0, cs.r}) * st;
        n_m1_z  = $signed({1'b0, cs.r}) * ct;
        n_m1_pol = cs.zero_a ? (cs.pi_a ? sc_pkg::PI_Q30 : '0) : ca.a;
        n_m1_az  = cs.zero_b ? (cs.pi_b ? sc_pkg::PI_Q30 : '0) : cb.a;
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_M1]) begin
            r_m1_side <= cs;
            r_m1_sp   <= n_m1_sp;
            r_m1_cp   <= n_m1_cp;
            r_m1_p    <= n_m1_p;
            r_m1_z    <= n_m1_z;
            r_m1_pol  <= n_m1_pol;
            r_m1_az   <= n_m1_az;
        end
    end

    // round the projection, finish z and the angles
    sc_pkg::t_cr_side         r_m2_side;
    logic signed [65:0]       tp;
    logic signed [34:0]       r_m2_p;
    logic signed [TRIG_W-1:0] r_m2_sp, r_m2_cp;
    logic signed [31:0]       r_m2_z, n_m2_z;
    logic signed [ANG_W:0]    azx;
    logic [18:0]              pol_q, az_q;
    logic [17:0]              r_m2_pol;
    logic [18:0]              r_m2_az;

    always_comb begin
        tp     = (r_m1_p + RND30P) >>> 30;
        n_m2_z = rnd_sat({{2{r_m1_z[65]}}, r_m1_z});
        pol_q  = to_q316({r_m1_pol[ANG_W-1], r_m1_pol}, {1'b0, sc_pkg::POLAR_MAX});
        azx    = {r_m1_az[ANG_W-1], r_m1_az};
        if (azx < 0) begin
            azx = azx + {sc_pkg::TWO_PI_Q30[ANG_W-1], sc_pkg::TWO_PI_Q30};
        end
        az_q = to_q316(azx, sc_pkg::AZIMUTH_MAX);
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_M2]) begin
            r_m2_side <= r_m1_side;
            r_m2_p    <= tp[34:0];
            r_m2_sp   <= r_m1_sp;
            r_m2_cp   <= r_m1_cp;
            r_m2_z    <= n_m2_z;
            r_m2_pol  <= pol_q[17:0];
            r_m2_az   <= az_q;
        end
    end

    // second products
    sc_pkg::t_cr_side   r_m3_side;
    logic signed [67:0] r_m3_x, r_m3_y, n_m3_x, n_m3_y;
    logic signed [31:0] r_m3_z;
    logic [17:0]        r_m3_pol;
    logic [18:0]        r_m3_az;

    always_comb begin
        n_m3_x = r_m2_p * r_m2_cp;
        n_m3_y = r_m2_p * r_m2_sp;
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_M3]) begin
            r_m3_side <= r_m2_side;
            r_m3_x    <= n_m3_x;
            r_m3_y    <= n_m3_y;
            r_m3_z    <= r_m2_z;
            r_m3_pol  <= r_m2_pol;
            r_m3_az   <= r_m2_az;
        end
    end

    // output register
    logic signed [31:0] r_x, r_y, r_z, n_x, n_y, n_z;
    logic [31:0]        r_rad, n_rad;
    logic [17:0]        r_pol, n_pol;
    logic [18:0]        r_az, n_az;
    logic               r_err, n_err;

    always_comb begin
        n_x   = '0;
        n_y   = '0;
        n_z   = '0;
        n_rad = '0;
        n_pol = '0;
        n_az  = '0;
        n_err = 1'b0;
        if (r_m3_side.func) begin
            n_rad = r_m3_side.rad;
            n_pol = r_m3_pol;
            n_az  = r_m3_az;
        end else if (r_m3_side.err) begin
            n_err = 1'b1;
        end else begin
            n_x = rnd_sat(r_m3_x);
            n_y = rnd_sat(r_m3_y);
            n_z = r_m3_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_OUT]) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_z   <= n_z;
            r_rad <= n_rad;
            r_pol <= n_pol;
            r_az  <= n_az;
            r_err <= n_err;
        end
    end

    assign o_x_out       = r_x;
    assign o_y_out       = r_y;
    assign o_z_out       = r_z;
    assign o_radius_out  = r_rad;
    assign o_polar_out   = r_pol;
    assign o_azimuth_out = r_az;
    assign o_range_error = r_err;

endmodule

`default_nettype wire

>>> design/sc_checker.sv
// Port-level assertions for the spherical/cartesian converter and the bind
// that attaches them. Depends on sc_pkg and spherical_cartesian_converter.
`timescale 1ns / 1ps
`default_nettype none

module sc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic               i_func,
    input logic [31:0]        i_radius_in,
    input logic [17:0]        i_polar_in,
    input logic [18:0]        i_azimuth_in,
    input logic signed [31:0] i_x_in,
    input logic signed [31:0] i_y_in,
    input logic signed [31:0] i_z_in,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [31:0] o_x_out,
    input logic signed [31:0] o_y_out,
    input logic signed [31:0] o_z_out,
    input logic [31:0]        o_radius_out,
    input logic [17:0]        o_polar_out,
    input logic [18:0]        o_azimuth_out,
    input logic               o_range_error
);

    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output beat after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_x_out) && $stable(o_y_out) &&
        $stable(o_z_out) && $stable(o_radius_out) && $stable(o_polar_out) &&
        $stable(o_azimuth_out) && $stable(o_range_error))
        else $error("stalled output beat changed");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("input held off without an output stall");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_range_error |-> o_x_out == 0 && o_y_out == 0 && o_z_out == 0 &&
        o_radius_out == 0 && o_polar_out == 0 && o_azimuth_out == 0)
        else $error("range error beat with non-zero fields");

    a_ang_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_polar_out <= sc_pkg::POLAR_MAX &&
        o_azimuth_out <= sc_pkg::AZIMUTH_MAX)
        else $error("output angle out of range");

endmodule

bind spherical_cartesian_converter sc_checker u_sc_checker (.*);

`default_nettype wire

>>> verif/spherical_cartesian_converter_test.sv
// Testbench for the spherical/cartesian converter: drives points with random
// gaps, predicts each result with an integer CORDIC model and checks in order.
// Depends on sc_pkg and spherical_cartesian_converter.
`timescale 1ns / 1ps

module spherical_cartesian_converter_test;

    localparam int STAGES = 20;
    localparam int DRAIN_CYCLES = 200;
    localparam int STALL_LIMIT = 5000;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [31:0]        radius;
        logic [17:0]        polar;
        logic [18:0]        azimuth;
        logic               range_error;
    } t_point_res;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               func = 1'b0;
    logic [31:0]        radius_in = '0;
    logic [17:0]        polar_in = '0;
    logic [18:0]        azimuth_in = '0;
    logic signed [31:0] x_in = '0;
    logic signed [31:0] y_in = '0;
    logic signed [31:0] z_in = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    t_point_res         got;

    t_point_res expected_points[$];
    int         error_count = 0;
    int         idle_cycles = 0;
    bit         hold_receiver = 1'b0;
    bit         sending_done = 1'b0;

    spherical_cartesian_converter #(.CORDIC_STAGES(STAGES)) u_top (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_ready(in_ready),
        .i_func(func), .i_radius_in(radius_in), .i_polar_in(polar_in),
        .i_azimuth_in(azimuth_in), .i_x_in(x_in), .i_y_in(y_in), .i_z_in(z_in),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_x_out(got.x), .o_y_out(got.y), .o_z_out(got.z),
        .o_radius_out(got.radius), .o_polar_out(got.polar),
        .o_azimuth_out(got.azimuth), .o_range_error(got.range_error)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic longint floor_shift(longint v, int s);
        if (v >= 0) return v >>> s;
        return -64'sd1 - ((-64'sd1 - v) >>> s);
    endfunction

    function automatic longint sat_s32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint round_q30(longint v);
        return floor_shift(v + (64'sd1 <<< 29), 30);
    endfunction

    function automatic longint atan_entry(int i);
        return longint'(sc_pkg::ATAN_TAB[i & 31]);
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    task automatic rotate_angle(input longint a, output longint s, output longint c);
        longint x, y, nx;
        bit neg;
        x = longint'(sc_pkg::GAIN_Q30);
        y = 0;
        neg = 1'b0;
        if (a > longint'(sc_pkg::HALF_PI_Q30)) begin
            a -= longint'(sc_pkg::PI_Q30);
            neg = 1'b1;
            if (a > longint'(sc_pkg::HALF_PI_Q30)) begin
                a -= longint'(sc_pkg::PI_Q30);
                neg = 1'b0;
            end
        end
        for (int i = 0; i < STAGES; i++) begin
            if (a >= 0) begin
                nx = x - floor_shift(y, i);
                y = y + floor_shift(x, i);
                a -= atan_entry(i);
            end else begin
                nx = x + floor_shift(y, i);
                y = y - floor_shift(x, i);
                a += atan_entry(i);
            end
            x = nx;
        end
        s = neg ? -y : y;
        c = neg ? -x : x;
    endtask

    function automatic longint vector_angle(longint yv, longint xv);
        longint x, y, ang, nx;
        if (yv == 0) return xv < 0 ? longint'(sc_pkg::PI_Q30) : 0;
        x = xv * 16777216;
        y = yv * 16777216;
        ang = 0;
        if (x < 0) begin
            x = -x;
            y = -y;
            ang = longint'(sc_pkg::PI_Q30);
        end
        for (int i = 0; i < STAGES; i++) begin
            if (y >= 0) begin
                nx = x + floor_shift(y, i);
                y = y - floor_shift(x, i);
                ang += atan_entry(i);
            end else begin
                nx = x - floor_shift(y, i);
                y = y + floor_shift(x, i);
                ang -= atan_entry(i);
            end
            x = nx;
        end
        return ang;
    endfunction

    function automatic longint angle_to_q316(longint a, longint hi);
        longint v;
        v = floor_shift(a + (64'sd1 <<< 13), 14);
        if (v < 0) v = 0;
        if (v > hi) v = hi;
        return v;
    endfunction

    task automatic predict_point(input logic f, input logic [31:0] r, input logic [17:0] pol,
                                 input logic [18:0] az, input logic signed [31:0] xi,
                                 input logic signed [31:0] yi,
                                 input logic signed [31:0] zi, output t_point_res res);
        longint st, ct, sp, cp, p, rl, xl, yl, zl, rho, azq;
        longint unsigned sxy;
        res = '0;
        if (!f) begin
            if (pol > sc_pkg::POLAR_MAX || az > sc_pkg::AZIMUTH_MAX) begin
                res.range_error = 1'b1;
                return;
            end
            rotate_angle(longint'(pol) <<< 14, st, ct);
            rotate_angle(longint'(az) <<< 14, sp, cp);
            rl = longint'(r);
            p = round_q30(rl * st);
            res.x = 32'(sat_s32(round_q30(p * cp)));
            res.y = 32'(sat_s32(round_q30(p * sp)));
            res.z = 32'(sat_s32(round_q30(rl * ct)));
        end else begin
            xl = xi;
            yl = yi;
            zl = zi;
            sxy = longint'(xl * xl) + longint'(yl * yl);
            res.radius = 32'(floor_sqrt(sxy + longint'(zl * zl)));
            rho = longint'(floor_sqrt(sxy));
            azq = vector_angle(yl, xl);
            if (azq < 0) azq += longint'(sc_pkg::TWO_PI_Q30);
            res.polar = 18'(angle_to_q316(vector_angle(rho, zl), sc_pkg::POLAR_MAX));
            res.azimuth = 19'(angle_to_q316(azq, sc_pkg::AZIMUTH_MAX));
        end
    endtask

    task automatic report_mismatch(input string what, input longint exp_v, input longint got_v);
        $display("MISMATCH %s: expected %0d got %0d at %0t", what, exp_v, got_v, $realtime);
        error_count++;
    endtask

    // One beat: optional gap, then hold valid until accepted.
    task automatic send_point(input logic f, input logic [31:0] r, input logic [17:0] pol,
                              input logic [18:0] az, input logic signed [31:0] xi,
                              input logic signed [31:0] yi, input logic signed [31:0] zi);
        t_point_res res;
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        predict_point(f, r, pol, az, xi, yi, zi, res);
        in_valid <= 1'b1;
        func <= f;
        radius_in <= r;
        polar_in <= pol;
        azimuth_in <= az;
        x_in <= xi;
        y_in <= yi;
        z_in <= zi;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        expected_points.push_back(res);
    endtask

    task automatic release_line();
        in_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_len();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 65535);
            1: return $urandom_range(0, 32'h00FF_FFFF);
            2: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random_spherical();
        logic [17:0] pol;
        logic [18:0] az;
        if ($urandom_range(0, 9) == 0) begin
            pol = 18'($urandom);
            az = 19'($urandom);
        end else begin
            pol = 18'($urandom_range(0, 205887));
            az = 19'($urandom_range(0, 411774));
        end
        send_point(1'b0, rand_len(), pol, az, $urandom, $urandom, $urandom);
    endtask

    task automatic send_random_cartesian();
        logic signed [31:0] c[3];
        for (int k = 0; k < 3; k++) begin
            case ($urandom_range(0, 4))
                0: c[k] = '0;
                1: c[k] = 32'($signed(17'($urandom)));
                2: c[k] = 32'($signed(25'($urandom)));
                default: c[k] = $urandom;
            endcase
        end
        send_point(1'b1, $urandom, 18'($urandom), 19'($urandom), c[0], c[1], c[2]);
    endtask

    task automatic test_directed();
        send_point(1'b0, 32'd0, 18'd0, 19'd0, 0, 0, 0);
        send_point(1'b0, 32'hFFFF_FFFF, 18'd0, 19'd0, 0, 0, 0);
        send_point(1'b0, 32'hFFFF_FFFF, 18'd205887, 19'd411774, 0, 0, 0);
        send_point(1'b0, 32'hFFFF_FFFF, 18'd102944, 19'd0, 0, 0, 0);
        send_point(1'b0, 32'hFFFF_FFFF, 18'd102944, 19'd205887, 0, 0, 0);
        send_point(1'b0, 32'h0001_0000, 18'd51472, 19'd308831, 0, 0, 0);
        send_point(1'b0, 32'h0001_0000, 18'd205888, 19'd0, 0, 0, 0);
        send_point(1'b0, 32'h0001_0000, 18'd0, 19'd411775, 0, 0, 0);
        send_point(1'b0, 32'hFFFF_FFFF, 18'h3FFFF, 19'h7FFFF, 0, 0, 0);
        send_point(1'b1, 0, 0, 0, 0, 0, 0);
        send_point(1'b1, 0, 0, 0, 32'sh0001_0000, 0, 0);
        send_point(1'b1, 0, 0, 0, -32'sh0001_0000, 0, 0);
        send_point(1'b1, 0, 0, 0, 0, 0, -32'sh0001_0000);
        send_point(1'b1, 0, 0, 0, 0, 0, 32'sh0001_0000);
        send_point(1'b1, 0, 0, 0, 0, 32'sh0001_0000, 0);
        send_point(1'b1, 0, 0, 0, 0, -32'sh0001_0000, 0);
        send_point(1'b1, 0, 0, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_point(1'b1, 0, 0, 0, -32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000);
        send_point(1'b1, 0, 0, 0, -32'sh8000_0000, -1, 32'sh7FFF_FFFF);
        send_point(1'b1, 32'hFFFF_FFFF, 18'h3FFFF, 19'h7FFFF, 1, -1, -1);
        send_point(1'b1, 0, 0, 0, 1, 0, 0);
        release_line();
    endtask

    task automatic test_random_mix(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 1)) send_random_spherical();
            else send_random_cartesian();
        end
        release_line();
    endtask

    // Receiver holds off long enough for the pipeline to fill and stall its input.
    task automatic test_backpressure();
        hold_receiver = 1'b1;
        fork
            begin
                for (int i = 0; i < 150; i++) begin
                    if ($urandom_range(0, 1)) send_random_spherical();
                    else send_random_cartesian();
                end
                release_line();
            end
            begin
                repeat (400) @(posedge clk);
                hold_receiver = 1'b0;
            end
        join
    endtask

    // Receiver: random stall per beat, with quiet stretches of none.
    initial begin
        int stall;
        @(posedge clk);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            if (hold_receiver || stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall > 0 ? stall : 1) @(posedge clk);
                while (hold_receiver) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    always @(posedge clk) begin
        t_point_res exp_p;
        if (rst_n && out_valid && out_ready) begin
            if (expected_points.size() == 0) begin
                report_mismatch("unexpected beat", 0, 1);
            end else begin
                exp_p = expected_points.pop_front();
                if (got.x !== exp_p.x) report_mismatch("x_out", exp_p.x, got.x);
                if (got.y !== exp_p.y) report_mismatch("y_out", exp_p.y, got.y);
                if (got.z !== exp_p.z) report_mismatch("z_out", exp_p.z, got.z);
                if (got.radius !== exp_p.radius)
                    report_mismatch("radius_out", exp_p.radius, got.radius);
                if (got.polar !== exp_p.polar)
                    report_mismatch("polar_out", exp_p.polar, got.polar);
                if (got.azimuth !== exp_p.azimuth)
                    report_mismatch("azimuth_out", exp_p.azimuth, got.azimuth);
                if (got.range_error !== exp_p.range_error)
                    report_mismatch("range_error", exp_p.range_error, got.range_error);
            end
        end
    end

    // Watchdog on cycles with no accepted beat on either side.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n
                || (sending_done && expected_points.size() == 0)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_mix(600);
        test_backpressure();
        test_random_mix(600);
        sending_done = 1'b1;
        while (expected_points.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
